### rtl/aclpq_pkg.sv
// shared types and constants for the ac line presence qualifier
`timescale 1ns / 1ps
package aclpq_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned REG_W    = 16;
    localparam int unsigned EDGE_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [REG_W-1:0] COUNT_MAX = {REG_W{1'b1}};

    localparam logic [REG_W-1:0] WINDOW_MS_RST       = 16'd250;
    localparam logic [REG_W-1:0] MIN_EDGES_RST       = 16'd6;
    localparam logic [REG_W-1:0] MIN_LOW_SAMPLES_RST = 16'd3;
    localparam logic [REG_W-1:0] ALERT_HOLD_MS_RST   = 16'd7000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_MS       = 2'd0,
        CFG_MIN_EDGES       = 2'd1,
        CFG_MIN_LOW_SAMPLES = 2'd2,
        CFG_ALERT_HOLD_MS   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_LOST     = 2'd1,
        EV_RESTORED = 2'd2
    } t_event;

    typedef struct packed {
        logic [REG_W-1:0] window_ms;
        logic [REG_W-1:0] min_edges;
        logic [REG_W-1:0] min_low_samples;
        logic [REG_W-1:0] alert_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              line_low;
        logic [EDGE_W-1:0] edges_added;
    } t_sample;

    typedef struct packed {
        logic   ac_present;
        logic   window_closed;
        t_event change_event;
        t_event alert_kind;
    } t_result;

endpackage

### rtl/aclpq_sample_if.sv
// sample channel interface
`timescale 1ns / 1ps
interface aclpq_sample_if;
    logic                           valid;
    logic                           ready;
    logic [aclpq_pkg::TIME_W-1:0]   time_ms;
    logic                           line_low;
    logic [aclpq_pkg::EDGE_W-1:0]   edges_added;

    modport source (output valid, output time_ms, output line_low, output edges_added,
                    input ready);
    modport sink   (input valid, input time_ms, input line_low, input edges_added,
                    output ready);
endinterface

### rtl/aclpq_result_if.sv
// result channel interface
`timescale 1ns / 1ps
interface aclpq_result_if;
    logic       valid;
    logic       ready;
    logic       ac_present;
    logic       window_closed;
    logic [1:0] change_event;
    logic [1:0] alert_kind;

    modport source (output valid, output ac_present, output window_closed,
                    output change_event, output alert_kind, input ready);
    modport sink   (input valid, input ac_present, input window_closed,
                    input change_event, input alert_kind, output ready);
endinterface

### rtl/aclpq_cfg_regs.sv
// configuration register bank
`timescale 1ns / 1ps
module aclpq_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [aclpq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [aclpq_pkg::REG_W-1:0]       i_cfg_data,
    output aclpq_pkg::t_cfg                   o_cfg
);

    aclpq_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ms       <= aclpq_pkg::WINDOW_MS_RST;
            r_cfg.min_edges       <= aclpq_pkg::MIN_EDGES_RST;
            r_cfg.min_low_samples <= aclpq_pkg::MIN_LOW_SAMPLES_RST;
            r_cfg.alert_hold_ms   <= aclpq_pkg::ALERT_HOLD_MS_RST;
        end else if (i_cfg_we) begin
            unique case (aclpq_pkg::t_cfg_idx'(i_cfg_idx))
                aclpq_pkg::CFG_WINDOW_MS:       r_cfg.window_ms       <= i_cfg_data;
                aclpq_pkg::CFG_MIN_EDGES:       r_cfg.min_edges       <= i_cfg_data;
                aclpq_pkg::CFG_MIN_LOW_SAMPLES: r_cfg.min_low_samples <= i_cfg_data;
                aclpq_pkg::CFG_ALERT_HOLD_MS:   r_cfg.alert_hold_ms   <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/aclpq_eval.sv
// window counters, presence decision and alert hold state
`timescale 1ns / 1ps
module aclpq_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  aclpq_pkg::t_sample  i_sample,
    input  aclpq_pkg::t_cfg     i_cfg,
    output aclpq_pkg::t_result  o_result
);

    logic [aclpq_pkg::TIME_W-1:0] r_window_start, n_window_start;
    logic [aclpq_pkg::REG_W-1:0]  r_edge_total, n_edge_total;
    logic [aclpq_pkg::REG_W-1:0]  r_low_total, n_low_total;
    logic                         r_present, n_present;
    logic                         r_started, n_started;
    aclpq_pkg::t_event            r_alert_type, n_alert_type;
    logic [aclpq_pkg::TIME_W-1:0] r_alert_end, n_alert_end;

    logic [aclpq_pkg::REG_W:0]    edge_sum;
    logic [aclpq_pkg::REG_W-1:0]  edge_acc;
    logic [aclpq_pkg::REG_W-1:0]  low_acc;
    logic [aclpq_pkg::TIME_W-1:0] elapsed;
    logic [aclpq_pkg::TIME_W-1:0] alert_left;
    logic                         closed;
    logic                         fresh;
    logic                         changed;
    logic                         alert_active;
    aclpq_pkg::t_event            event_code;
    aclpq_pkg::t_event            alert_pre;

    always_comb begin
        edge_sum = {1'b0, r_edge_total}
                 + {{(aclpq_pkg::REG_W + 1 - aclpq_pkg::EDGE_W){1'b0}}, i_sample.edges_added};
        edge_acc = edge_sum[aclpq_pkg::REG_W] ? aclpq_pkg::COUNT_MAX
                                              : edge_sum[aclpq_pkg::REG_W-1:0];
        low_acc  = (i_sample.line_low && (r_low_total != aclpq_pkg::COUNT_MAX))
                 ? r_low_total + 1'b1 : r_low_total;

        elapsed = i_sample.time_ms - r_window_start;
        closed  = elapsed >= {{(aclpq_pkg::TIME_W - aclpq_pkg::REG_W){1'b0}}, i_cfg.window_ms};
        fresh   = (edge_acc >= i_cfg.min_edges) || (low_acc >= i_cfg.min_low_samples);
        changed = closed && r_started && (fresh != r_present);

        event_code = changed ? (fresh ? aclpq_pkg::EV_RESTORED : aclpq_pkg::EV_LOST)
                             : aclpq_pkg::EV_NONE;
        alert_pre  = changed ? event_code : r_alert_type;

        // a fresh alert has exactly the hold time left
        alert_left = r_alert_end - i_sample.time_ms;
        if (changed) begin
            alert_active = i_cfg.alert_hold_ms != '0;
        end else begin
            alert_active = (r_alert_type != aclpq_pkg::EV_NONE) && (alert_left != '0)
                         && !alert_left[aclpq_pkg::TIME_W-1];
        end

        n_edge_total   = closed ? '0 : edge_acc;
        n_low_total    = closed ? '0 : low_acc;
        n_window_start = closed ? i_sample.time_ms : r_window_start;
        n_started      = r_started || closed;
        n_present      = closed ? fresh : r_present;
        n_alert_type   = alert_active ? alert_pre : aclpq_pkg::EV_NONE;
        n_alert_end    = changed
                       ? i_sample.time_ms
                         + {{(aclpq_pkg::TIME_W - aclpq_pkg::REG_W){1'b0}}, i_cfg.alert_hold_ms}
                       : r_alert_end;

        o_result.ac_present    = n_present;
        o_result.window_closed = closed;
        o_result.change_event  = event_code;
        o_result.alert_kind    = n_alert_type;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_start <= '0;
            r_edge_total   <= '0;
            r_low_total    <= '0;
            r_present      <= 1'b0;
            r_started      <= 1'b0;
            r_alert_type   <= aclpq_pkg::EV_NONE;
            r_alert_end    <= '0;
        end else if (i_fire) begin
            r_window_start <= n_window_start;
            r_edge_total   <= n_edge_total;
            r_low_total    <= n_low_total;
            r_present      <= n_present;
            r_started      <= n_started;
            r_alert_type   <= n_alert_type;
            r_alert_end    <= n_alert_end;
        end
    end

endmodule

### rtl/ac_line_presence_qualifier_core.sv
// top level of the ac line presence qualifier
// usage:
//   i_sample carries one word per sample: millisecond timestamp, sense level and
//   the edge count since the previous sample. o_result returns one word per
//   sample: presence, window closed flag, change event and active alert kind.
//   configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// pipeline and throughput:
//   a word accepted into the input register is evaluated and written to the
//   result register, which presents it on o_result. one word per cycle is
//   sustained while o_result is taken; the counter and alert state are updated
//   combinationally between the input register and the result register.
// reset:
//   synchronous active-low reset clears the counts, presence, alert state and
//   the valid flags of both pipeline registers and reloads the default configuration.
// stall:
//   when o_result is held, the result register keeps its word and the input
//   register still takes one more word; i_sample.ready then drops until the
//   result is taken.
`timescale 1ns / 1ps
module ac_line_presence_qualifier_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    aclpq_sample_if.sink                      i_sample,
    aclpq_result_if.source                    o_result,
    input  logic                              i_cfg_we,
    input  logic [aclpq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [aclpq_pkg::REG_W-1:0]       i_cfg_data
);

    aclpq_pkg::t_cfg     cfg;
    aclpq_pkg::t_sample  r_in_data;
    logic                r_in_valid;
    aclpq_pkg::t_result  eval_result;
    aclpq_pkg::t_result  r_out_data;
    logic                r_out_valid;
    logic                fire;
    logic                in_take;

    aclpq_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    aclpq_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_sample (r_in_data),
        .i_cfg    (cfg),
        .o_result (eval_result)
    );

    assign fire           = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || fire;
    assign in_take        = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data.time_ms     <= i_sample.time_ms;
            r_in_data.line_low    <= i_sample.line_low;
            r_in_data.edges_added <= i_sample.edges_added;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= eval_result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.ac_present    = r_out_data.ac_present;
    assign o_result.window_closed = r_out_data.window_closed;
    assign o_result.change_event  = r_out_data.change_event;
    assign o_result.alert_kind    = r_out_data.alert_kind;

    // an event only comes with a closed window
    a_event_needs_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.change_event != aclpq_pkg::EV_NONE))
        |-> r_out_data.window_closed)
        else $error("change event without closed window");

    // event direction agrees with presence
    a_event_matches_presence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.change_event != aclpq_pkg::EV_NONE))
        |-> (r_out_data.ac_present == (r_out_data.change_event == aclpq_pkg::EV_RESTORED)))
        else $error("change event disagrees with presence");

    // input side stalls only with both registers full and the receiver holding
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sample.ready |-> (r_in_valid && r_out_valid && !o_result.ready))
        else $error("input stalled without a full pipeline");

    // a held result word does not change
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("held result changed");

endmodule

### verif/ac_line_presence_qualifier_core_tb.sv
// self-checking testbench for the ac line presence qualifier core
`timescale 1ns / 1ps
module ac_line_presence_qualifier_core_tb;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [aclpq_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [aclpq_pkg::REG_W-1:0]     i_cfg_data;

    aclpq_sample_if sample_if ();
    aclpq_result_if result_if ();

    ac_line_presence_qualifier_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample_if),
        .o_result   (result_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    aclpq_pkg::t_cfg              cfg_now;
    logic [aclpq_pkg::TIME_W-1:0] win_start_ms;
    logic [aclpq_pkg::REG_W-1:0]  edge_sum;
    logic [aclpq_pkg::REG_W-1:0]  low_sum;
    logic                         ac_up;
    logic                         primed;
    aclpq_pkg::t_event            alert_now;
    logic [aclpq_pkg::TIME_W-1:0] alert_deadline;

    aclpq_pkg::t_result           expected_q[$];
    int unsigned                  mismatches;
    int unsigned                  cycles;

    // stimulus state
    logic [aclpq_pkg::TIME_W-1:0] clock_ms;
    bit                           lively;
    int unsigned                  step_max;
    int                           burst_left;
    int                           stall_left;
    int unsigned                  stall_mode;
    int unsigned                  stall_phase;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic reset_presence_model();
        cfg_now.window_ms       = aclpq_pkg::WINDOW_MS_RST;
        cfg_now.min_edges       = aclpq_pkg::MIN_EDGES_RST;
        cfg_now.min_low_samples = aclpq_pkg::MIN_LOW_SAMPLES_RST;
        cfg_now.alert_hold_ms   = aclpq_pkg::ALERT_HOLD_MS_RST;
        win_start_ms   = '0;
        edge_sum       = '0;
        low_sum        = '0;
        ac_up          = 1'b0;
        primed         = 1'b0;
        alert_now      = aclpq_pkg::EV_NONE;
        alert_deadline = '0;
    endtask

    function automatic aclpq_pkg::t_result qualify_sample(input aclpq_pkg::t_sample s);
        aclpq_pkg::t_result           r;
        logic [aclpq_pkg::REG_W:0]    edge_wide;
        logic [aclpq_pkg::TIME_W-1:0] span;
        logic [aclpq_pkg::TIME_W-1:0] remain;
        logic                         fresh;
        r = '0;
        edge_wide = {1'b0, edge_sum} + (aclpq_pkg::REG_W + 1)'(s.edges_added);
        edge_sum = edge_wide[aclpq_pkg::REG_W] ? aclpq_pkg::COUNT_MAX
                                               : edge_wide[aclpq_pkg::REG_W-1:0];
        if (s.line_low && low_sum != aclpq_pkg::COUNT_MAX) begin
            low_sum = low_sum + 1'b1;
        end
        span = s.time_ms - win_start_ms;
        if (span >= (aclpq_pkg::TIME_W)'(cfg_now.window_ms)) begin
            fresh = (edge_sum >= cfg_now.min_edges) || (low_sum >= cfg_now.min_low_samples);
            r.window_closed = 1'b1;
            edge_sum = '0;
            low_sum = '0;
            if (!primed) begin
                ac_up = fresh;
                primed = 1'b1;
            end else if (fresh != ac_up) begin
                ac_up = fresh;
                r.change_event = fresh ? aclpq_pkg::EV_RESTORED : aclpq_pkg::EV_LOST;
                alert_now = r.change_event;
                alert_deadline = s.time_ms + (aclpq_pkg::TIME_W)'(cfg_now.alert_hold_ms);
            end
            win_start_ms = s.time_ms;
        end
        // alert holds while the signed distance to its deadline stays positive
        remain = alert_deadline - s.time_ms;
        if (alert_now == aclpq_pkg::EV_NONE || remain == '0
            || remain[aclpq_pkg::TIME_W-1]) begin
            alert_now = aclpq_pkg::EV_NONE;
        end
        r.ac_present = ac_up;
        r.alert_kind = alert_now;
        return r;
    endfunction

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(64, 256);
        end else begin
            stall_left--;
        end
        stall_phase++;
        case (stall_mode)
            0: result_if.ready <= 1'b1;
            1: result_if.ready <= ($urandom_range(0, 3) != 0);
            2: result_if.ready <= (stall_phase % 3 == 0);
            default: result_if.ready <= ($urandom_range(0, 9) > 6);
        endcase
    end

    always @(posedge i_clk) begin : check_results
        aclpq_pkg::t_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word at cycle %0d", cycles);
                end
            end else begin
                want = expected_q.pop_front();
                if (result_if.ac_present !== want.ac_present ||
                    result_if.window_closed !== want.window_closed ||
                    result_if.change_event !== want.change_event ||
                    result_if.alert_kind !== want.alert_kind) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at cycle %0d: expected %0b %0b %0d %0d, got %0b %0b %0d %0d",
                                 cycles, want.ac_present, want.window_closed,
                                 want.change_event, want.alert_kind,
                                 result_if.ac_present, result_if.window_closed,
                                 result_if.change_event, result_if.alert_kind);
                    end
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(input aclpq_pkg::t_sample s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                sample_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        sample_if.valid       <= 1'b1;
        sample_if.time_ms     <= s.time_ms;
        sample_if.line_low    <= s.line_low;
        sample_if.edges_added <= s.edges_added;
        do begin
            @(posedge i_clk);
        end while (!sample_if.ready);
        expected_q.push_back(qualify_sample(s));
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic [aclpq_pkg::TIME_W-1:0] t, input logic low,
                               input logic [aclpq_pkg::EDGE_W-1:0] e);
        aclpq_pkg::t_sample s;
        s.time_ms = t;
        s.line_low = low;
        s.edges_added = e;
        send_sample(s);
    endtask

    task automatic wait_drained();
        sample_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic put_reg(input aclpq_pkg::t_cfg_idx idx,
                           input logic [aclpq_pkg::REG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic write_config(input aclpq_pkg::t_cfg c);
        put_reg(aclpq_pkg::CFG_WINDOW_MS, c.window_ms);
        put_reg(aclpq_pkg::CFG_MIN_EDGES, c.min_edges);
        put_reg(aclpq_pkg::CFG_MIN_LOW_SAMPLES, c.min_low_samples);
        put_reg(aclpq_pkg::CFG_ALERT_HOLD_MS, c.alert_hold_ms);
        i_cfg_we <= 1'b0;
        cfg_now = c;
    endtask

    function automatic aclpq_pkg::t_sample next_sample();
        aclpq_pkg::t_sample s;
        int unsigned        roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            clock_ms = $urandom();
            s.time_ms = clock_ms;
        end else if (roll < 8) begin
            s.time_ms = clock_ms - $urandom_range(1, 50);
        end else begin
            clock_ms = clock_ms + $urandom_range(0, step_max);
            s.time_ms = clock_ms;
        end
        if ($urandom_range(0, 99) < 5) begin
            lively = !lively;
        end
        if (lively) begin
            s.edges_added = ($urandom_range(0, 9) == 0)
                          ? (aclpq_pkg::EDGE_W)'($urandom_range(0, 255))
                          : (aclpq_pkg::EDGE_W)'($urandom_range(0, 4));
            s.line_low = 1'($urandom_range(0, 1));
        end else begin
            s.edges_added = ($urandom_range(0, 19) == 0) ? (aclpq_pkg::EDGE_W)'(1)
                                                         : (aclpq_pkg::EDGE_W)'(0);
            s.line_low = ($urandom_range(0, 11) == 0);
        end
        return s;
    endfunction

    task automatic test_directed_cases();
        aclpq_pkg::t_cfg c;
        // default registers: first window, loss, restore, wrap and backwards time
        send_fields(32'd0, 1'b0, 8'd0);
        send_fields(32'd250, 1'b0, 8'd6);
        send_fields(32'd500, 1'b0, 8'd0);
        send_fields(32'd600, 1'b0, 8'd0);
        send_fields(32'd700, 1'b1, 8'd0);
        send_fields(32'd710, 1'b1, 8'd0);
        send_fields(32'd750, 1'b1, 8'd0);
        send_fields(32'hFFFF_FFFF, 1'b0, 8'hFF);
        send_fields(32'd5, 1'b1, 8'hFF);
        send_fields(32'd3, 1'b0, 8'd0);
        send_fields(32'd7750, 1'b0, 8'd0);
        wait_drained();
        // zero window and zero hold
        c = '{window_ms: 16'd0, min_edges: aclpq_pkg::COUNT_MAX,
              min_low_samples: aclpq_pkg::COUNT_MAX, alert_hold_ms: 16'd0};
        write_config(c);
        send_fields(32'd8000, 1'b0, 8'd0);
        send_fields(32'd8000, 1'b1, 8'hFF);
        wait_drained();
        c = '{window_ms: 16'd0, min_edges: 16'd0, min_low_samples: 16'd0,
              alert_hold_ms: 16'd0};
        write_config(c);
        send_fields(32'd8001, 1'b0, 8'd0);
        wait_drained();
        c = '{window_ms: 16'd1, min_edges: 16'd1, min_low_samples: 16'd1,
              alert_hold_ms: aclpq_pkg::COUNT_MAX};
        write_config(c);
        send_fields(32'd8001, 1'b0, 8'd1);
        send_fields(32'd8002, 1'b0, 8'd0);
        send_fields(32'd8003, 1'b1, 8'd0);
        wait_drained();
    endtask

    task automatic test_count_saturation();
        aclpq_pkg::t_cfg              c;
        logic [aclpq_pkg::TIME_W-1:0] t0;
        int                           i;
        c = '{window_ms: aclpq_pkg::COUNT_MAX, min_edges: aclpq_pkg::COUNT_MAX,
              min_low_samples: aclpq_pkg::COUNT_MAX, alert_hold_ms: 16'd100};
        write_config(c);
        t0 = win_start_ms + 32'd65535;
        send_fields(t0, 1'b0, 8'd0);
        for (i = 0; i < 258; i++) begin
            send_fields(t0 + 32'd1, 1'b0, 8'hFF);
        end
        send_fields(t0 + 32'd65535, 1'b0, 8'd0);
        for (i = 0; i < 10; i++) begin
            send_fields(t0 + 32'd65536, 1'b1, 8'd0);
        end
        send_fields(t0 + 32'd131070, 1'b0, 8'd0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        aclpq_pkg::t_cfg c;
        int              p;
        int              i;
        for (p = 0; p < 6; p++) begin
            case (p)
                0: c = '{window_ms: 16'd1, min_edges: 16'd0, min_low_samples: 16'd0,
                         alert_hold_ms: 16'd1};
                1: c = '{window_ms: aclpq_pkg::COUNT_MAX, min_edges: aclpq_pkg::COUNT_MAX,
                         min_low_samples: aclpq_pkg::COUNT_MAX,
                         alert_hold_ms: aclpq_pkg::COUNT_MAX};
                default: c = '{window_ms: 16'($urandom_range(2, 40)),
                               min_edges: 16'($urandom_range(1, 20)),
                               min_low_samples: 16'($urandom_range(1, 6)),
                               alert_hold_ms: 16'($urandom_range(1, 200))};
            endcase
            // one phase runs across the timestamp wrap
            clock_ms = (p == 2) ? 32'hFFFF_FF80 : win_start_ms;
            step_max = c.window_ms / 4 + 1;
            write_config(c);
            for (i = 0; i < 60; i++) begin
                if (p == 3 && i == 30) begin
                    wait_drained();
                end
                send_sample(next_sample());
            end
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = aclpq_pkg::CFG_WINDOW_MS;
        i_cfg_data            = '0;
        sample_if.valid       = 1'b0;
        sample_if.time_ms     = '0;
        sample_if.line_low    = 1'b0;
        sample_if.edges_added = '0;
        result_if.ready       = 1'b0;
        mismatches  = 0;
        cycles      = 0;
        burst_left  = 0;
        stall_left  = 0;
        stall_mode  = 0;
        stall_phase = 0;
        clock_ms    = '0;
        lively      = 1'b0;
        step_max    = 8;
        reset_presence_model();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_cases();
        test_count_saturation();
        test_random_traffic();
        wait_drained();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
